// ===== src/ubtb_pkg.sv =====
// ----------------------------------------------------------------------------
// ubtb_pkg
// Shared types and constants for the micro branch target buffer.
// ----------------------------------------------------------------------------
package ubtb_pkg;

  localparam int ENTRIES_DEF    = 32;
  localparam int ADDR_WIDTH_DEF = 48;

  localparam int CMD_W  = 2;
  localparam int SIZE_W = 4;
  localparam int KIND_W = 3;
  localparam int CONF_W = 2;

  localparam logic [CONF_W-1:0] CONF_ZERO = 2'd0;
  localparam logic [CONF_W-1:0] CONF_INIT = 2'd1;
  localparam logic [CONF_W-1:0] CONF_MAX  = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PREDICT = 2'd0,
    CMD_UPDATE  = 2'd1,
    CMD_COMMIT  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EXEC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic              load;
    logic              look;
    logic              wr_entry;
    logic              wr_conf;
    logic [CONF_W-1:0] conf_val;
    logic              touch;
    logic              emit;
  } dp_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              hit;
    logic              guard_ok;
    logic              cpc_eq;
    logic              tgt_eq;
    logic [CONF_W-1:0] conf;
  } dp_stat_t;

endpackage

// ===== src/ubtb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ubtb_ctrl
// Sequencer: accept, lookup, execute. Decides writes, hysteresis and recency.
// ----------------------------------------------------------------------------
module ubtb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ubtb_pkg::dp_stat_t stat,
  output ubtb_pkg::dp_ctrl_t ctl
);
  import ubtb_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [CONF_W-1:0] conf_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign conf_dec = (stat.conf == CONF_ZERO) ? CONF_ZERO : stat.conf - CONF_W'(1);

  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        ctl.look   = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        unique case (stat.cmd)
          CMD_PREDICT: begin
            ctl.emit  = 1'b1;
            ctl.touch = stat.hit;
          end
          CMD_UPDATE: begin
            if (stat.guard_ok) begin
              if (!stat.hit) begin
                ctl.wr_entry = 1'b1;
                ctl.conf_val = CONF_INIT;
                ctl.touch    = 1'b1;
              end else if (!stat.cpc_eq && !stat.tgt_eq) begin
                if (conf_dec == CONF_ZERO) begin
                  ctl.wr_entry = 1'b1;
                  ctl.conf_val = CONF_ZERO;
                  ctl.touch    = 1'b1;
                end else begin
                  ctl.wr_conf  = 1'b1;
                  ctl.conf_val = conf_dec;
                end
              end
            end
          end
          CMD_COMMIT: begin
            if (stat.hit && stat.cpc_eq && stat.tgt_eq) begin
              ctl.wr_conf  = 1'b1;
              ctl.conf_val = (stat.conf >= CONF_MAX) ? CONF_MAX : stat.conf + CONF_W'(1);
            end
          end
          default: ;
        endcase
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== src/ubtb_dp.sv =====
// ----------------------------------------------------------------------------
// ubtb_dp
// Tags, valid bits and recency ranks in flops; entry payload in a memory.
// ----------------------------------------------------------------------------
module ubtb_dp #(
  parameter int ENTRIES    = ubtb_pkg::ENTRIES_DEF,
  parameter int ADDR_WIDTH = ubtb_pkg::ADDR_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ubtb_pkg::dp_ctrl_t            ctl,
  output ubtb_pkg::dp_stat_t            stat,
  input  logic [ubtb_pkg::CMD_W-1:0]    cmd,
  input  logic [ADDR_WIDTH-1:0]         fetch_addr,
  input  logic [ADDR_WIDTH-1:0]         stream_base,
  input  logic [ADDR_WIDTH-1:0]         branch_pc,
  input  logic [ADDR_WIDTH-1:0]         target,
  input  logic [ubtb_pkg::SIZE_W-1:0]   branch_size,
  input  logic [ubtb_pkg::KIND_W-1:0]   end_kind,
  output logic                          res_valid,
  output logic                          hit,
  output logic [ADDR_WIDTH-1:0]         block_start,
  output logic [ADDR_WIDTH-1:0]         pred_control_addr,
  output logic [ubtb_pkg::SIZE_W-1:0]   pred_branch_size,
  output logic [ADDR_WIDTH-1:0]         pred_next_stream,
  output logic [ubtb_pkg::KIND_W-1:0]   pred_end_kind
);
  import ubtb_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int MEM_W  = 2 * ADDR_WIDTH + SIZE_W + KIND_W + CONF_W;
  localparam int KIND_L = CONF_W;
  localparam int SIZE_L = KIND_L + KIND_W;
  localparam int TGT_L  = SIZE_L + SIZE_W;
  localparam int CPC_L  = TGT_L + ADDR_WIDTH;
  localparam logic [IDX_W-1:0] RANK_TOP = IDX_W'(ENTRIES - 1);

  logic [CMD_W-1:0]      cmd_q;
  logic [ADDR_WIDTH-1:0] chunk_q;
  logic [ADDR_WIDTH-1:0] sstart_q;
  logic [ADDR_WIDTH-1:0] cpc_q;
  logic [ADDR_WIDTH-1:0] tgt_q;
  logic [SIZE_W-1:0]     size_q;
  logic [KIND_W-1:0]     kind_q;

  logic [ENTRIES-1:0]    valid;
  logic [ADDR_WIDTH-1:0] tag  [ENTRIES];
  logic [IDX_W-1:0]      rank [ENTRIES];
  logic [MEM_W-1:0]      mem  [ENTRIES];
  logic [MEM_W-1:0]      rdata;
  logic [MEM_W-1:0]      wdata;

  logic [ADDR_WIDTH-1:0] key;
  logic                  hit_any;
  logic [IDX_W-1:0]      hit_idx;
  logic                  free_any;
  logic [IDX_W-1:0]      free_idx;
  logic [IDX_W-1:0]      lru_idx;
  logic [IDX_W-1:0]      sel_idx;
  logic [IDX_W-1:0]      old_rank;

  logic                  hit_q;
  logic                  guard_q;
  logic [IDX_W-1:0]      sel_q;
  logic [IDX_W-1:0]      old_q;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q    <= cmd;
      chunk_q  <= fetch_addr;
      sstart_q <= stream_base;
      cpc_q    <= branch_pc;
      tgt_q    <= target;
      size_q   <= branch_size;
      kind_q   <= end_kind;
    end
  end

  assign key = (cmd_q == CMD_COMMIT) ? sstart_q : chunk_q;

  // lowest index wins; invalid entries keep index order among their ranks
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    lru_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && tag[i] == key) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
      if (rank[i] == '0) begin
        lru_idx = IDX_W'(i);
      end
    end
  end

  assign sel_idx = hit_any ? hit_idx : (free_any ? free_idx : lru_idx);

  always_comb begin
    old_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel_idx == IDX_W'(i)) begin
        old_rank = old_rank | rank[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.look) begin
      hit_q   <= hit_any;
      guard_q <= (cpc_q >= sstart_q);
      sel_q   <= sel_idx;
      old_q   <= old_rank;
    end
  end

  assign wdata = ctl.wr_entry ? {cpc_q, tgt_q, size_q, kind_q, ctl.conf_val}
                              : {rdata[MEM_W-1:CONF_W], ctl.conf_val};

  always_ff @(posedge clk) begin
    if (ctl.look) begin
      rdata <= mem[sel_idx];
    end
    if (ctl.wr_entry || ctl.wr_conf) begin
      mem[sel_q] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_entry) begin
      tag[sel_q] <= chunk_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.wr_entry) begin
      valid[sel_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= IDX_W'(i);
      end
    end else if (ctl.touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (sel_q == IDX_W'(i)) begin
          rank[i] <= RANK_TOP;
        end else if (rank[i] > old_q) begin
          rank[i] <= rank[i] - IDX_W'(1);
        end
      end
    end
  end

  assign stat.cmd      = cmd_q;
  assign stat.hit      = hit_q;
  assign stat.guard_ok = guard_q;
  assign stat.cpc_eq   = (rdata[CPC_L +: ADDR_WIDTH] == cpc_q);
  assign stat.tgt_eq   = (rdata[TGT_L +: ADDR_WIDTH] == tgt_q);
  assign stat.conf     = rdata[CONF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      hit               <= hit_q;
      block_start       <= hit_q ? chunk_q : '0;
      pred_control_addr <= hit_q ? rdata[CPC_L +: ADDR_WIDTH] : '0;
      pred_next_stream  <= hit_q ? rdata[TGT_L +: ADDR_WIDTH] : '0;
      pred_branch_size  <= hit_q ? rdata[SIZE_L +: SIZE_W] : '0;
      pred_end_kind     <= hit_q ? rdata[KIND_L +: KIND_W] : '0;
    end
  end

endmodule

// ===== src/micro_btb_lru_hysteresis.sv =====
// ----------------------------------------------------------------------------
// micro_btb_lru_hysteresis
// Fully associative micro BTB with LRU replacement and 2-bit hysteresis.
//
//   channel  handshake             payload
//   input    start & !busy         cmd, fetch_addr, stream_base, branch_pc,
//                                  target, branch_size, end_kind
//   result   res_valid (1 cycle)   hit, block_start, pred_control_addr,
//                                  pred_branch_size, pred_next_stream,
//                                  pred_end_kind
//
// Each item goes through accept, lookup (parallel tag compare plus one read
// of the entry store) and execute (write-back and recency update).
// A predict result is shown for one cycle after the execute cycle.
// Reset clears the valid bits and sets each rank to its index; no sweep.
// The receiver cannot stall; busy is high from accept until execute ends.
// ----------------------------------------------------------------------------
module micro_btb_lru_hysteresis #(
  parameter int ENTRIES    = ubtb_pkg::ENTRIES_DEF,
  parameter int ADDR_WIDTH = ubtb_pkg::ADDR_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [ubtb_pkg::CMD_W-1:0]  cmd,
  input  logic [ADDR_WIDTH-1:0]       fetch_addr,
  input  logic [ADDR_WIDTH-1:0]       stream_base,
  input  logic [ADDR_WIDTH-1:0]       branch_pc,
  input  logic [ADDR_WIDTH-1:0]       target,
  input  logic [ubtb_pkg::SIZE_W-1:0] branch_size,
  input  logic [ubtb_pkg::KIND_W-1:0] end_kind,
  output logic                        res_valid,
  output logic                        hit,
  output logic [ADDR_WIDTH-1:0]       block_start,
  output logic [ADDR_WIDTH-1:0]       pred_control_addr,
  output logic [ubtb_pkg::SIZE_W-1:0] pred_branch_size,
  output logic [ADDR_WIDTH-1:0]       pred_next_stream,
  output logic [ubtb_pkg::KIND_W-1:0] pred_end_kind
);
  import ubtb_pkg::*;

  dp_ctrl_t ctl;
  dp_stat_t stat;

  ubtb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctl   (ctl)
  );

  ubtb_dp #(
    .ENTRIES    (ENTRIES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .stat              (stat),
    .cmd               (cmd),
    .fetch_addr        (fetch_addr),
    .stream_base       (stream_base),
    .branch_pc         (branch_pc),
    .target            (target),
    .branch_size       (branch_size),
    .end_kind          (end_kind),
    .res_valid         (res_valid),
    .hit               (hit),
    .block_start       (block_start),
    .pred_control_addr (pred_control_addr),
    .pred_branch_size  (pred_branch_size),
    .pred_next_stream  (pred_next_stream),
    .pred_end_kind     (pred_end_kind)
  );

endmodule

// ===== test/micro_btb_lru_hysteresis_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// micro_btb_lru_hysteresis_test
// Sends predict, update and commit transfers into the micro BTB and keeps a
// shadow of the entry store, hysteresis counters and LRU ranks. Every predict
// result is checked field by field against the shadow; stray results, wrong
// fields and a stalled block are flagged.
// ----------------------------------------------------------------------------
module micro_btb_lru_hysteresis_test;
  import ubtb_pkg::*;

  localparam int AW            = ADDR_WIDTH_DEF;
  localparam int NENT          = ENTRIES_DEF;
  localparam int POOL          = 40;
  localparam int RANDOM_ITEMS  = 1530;
  localparam int STALL_LIMIT   = 500;
  localparam int SETTLE_CYCLES = 10;

  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  typedef logic [AW-1:0] addr_t;

  localparam addr_t ADDR_ALT_A = 48'hAAAA_AAAA_AAAA;
  localparam addr_t ADDR_ALT_5 = 48'h5555_5555_5555;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    addr_t             chunk;
    addr_t             sstart;
    addr_t             cpc;
    addr_t             tgt;
    logic [SIZE_W-1:0] size;
    logic [KIND_W-1:0] kind;
  } fetch_req_t;

  typedef struct packed {
    logic              hit;
    addr_t             block;
    addr_t             ctrl;
    logic [SIZE_W-1:0] size;
    addr_t             next;
    logic [KIND_W-1:0] kind;
  } lookup_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  cmd;
  addr_t             fetch_addr;
  addr_t             stream_base;
  addr_t             branch_pc;
  addr_t             target;
  logic [SIZE_W-1:0] branch_size;
  logic [KIND_W-1:0] end_kind;
  logic              res_valid;
  logic              hit;
  addr_t             block_start;
  addr_t             pred_control_addr;
  logic [SIZE_W-1:0] pred_branch_size;
  addr_t             pred_next_stream;
  logic [KIND_W-1:0] pred_end_kind;

  // shadow of the entry store
  logic              sh_valid [NENT];
  addr_t             sh_tag   [NENT];
  addr_t             sh_ctrl  [NENT];
  logic [SIZE_W-1:0] sh_size  [NENT];
  addr_t             sh_next  [NENT];
  logic [KIND_W-1:0] sh_kind  [NENT];
  logic [CONF_W-1:0] sh_conf  [NENT];
  int                sh_rank  [NENT];

  lookup_t lookups_due [$];
  int      errors;
  int      stall_cycles;
  bit      gaps_on;

  addr_t             pool_tag  [POOL];
  addr_t             pool_cpc  [POOL];
  addr_t             pool_tgt  [POOL];
  logic [SIZE_W-1:0] pool_size [POOL];
  logic [KIND_W-1:0] pool_kind [POOL];

  micro_btb_lru_hysteresis u_top (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .cmd               (cmd),
    .fetch_addr        (fetch_addr),
    .stream_base       (stream_base),
    .branch_pc         (branch_pc),
    .target            (target),
    .branch_size       (branch_size),
    .end_kind          (end_kind),
    .res_valid         (res_valid),
    .hit               (hit),
    .block_start       (block_start),
    .pred_control_addr (pred_control_addr),
    .pred_branch_size  (pred_branch_size),
    .pred_next_stream  (pred_next_stream),
    .pred_end_kind     (pred_end_kind)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic addr_t rand_addr();
    return addr_t'({$urandom(), $urandom()});
  endfunction

  function automatic fetch_req_t req_of(logic [CMD_W-1:0] op, addr_t chunk, addr_t sstart,
                                        addr_t cpc, addr_t tgt, logic [SIZE_W-1:0] size,
                                        logic [KIND_W-1:0] kind);
    fetch_req_t r;
    r.op     = op;
    r.chunk  = chunk;
    r.sstart = sstart;
    r.cpc    = cpc;
    r.tgt    = tgt;
    r.size   = size;
    r.kind   = kind;
    return r;
  endfunction

  function automatic int sh_find(addr_t key);
    for (int i = 0; i < NENT; i++) begin
      if (sh_valid[i] && sh_tag[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void sh_promote(int idx);
    int old;
    old = sh_rank[idx];
    for (int i = 0; i < NENT; i++) begin
      if (sh_rank[i] > old) sh_rank[i] = sh_rank[i] - 1;
    end
    sh_rank[idx] = NENT - 1;
  endfunction

  // invalid entries first, oldest among them; else the LRU entry
  function automatic int sh_victim();
    int pick;
    pick = -1;
    for (int i = 0; i < NENT; i++) begin
      if (!sh_valid[i] && (pick < 0 || sh_rank[i] < sh_rank[pick])) pick = i;
    end
    if (pick >= 0) return pick;
    for (int i = 0; i < NENT; i++) begin
      if (sh_rank[i] == 0) return i;
    end
    return 0;
  endfunction

  function automatic void sh_fill(int idx, fetch_req_t r, logic [CONF_W-1:0] conf);
    sh_valid[idx] = 1'b1;
    sh_tag[idx]   = r.chunk;
    sh_ctrl[idx]  = r.cpc;
    sh_size[idx]  = r.size;
    sh_next[idx]  = r.tgt;
    sh_kind[idx]  = r.kind;
    sh_conf[idx]  = conf;
  endfunction

  function automatic void sh_apply(fetch_req_t r);
    lookup_t res;
    int      idx;
    case (r.op)
      CMD_PREDICT: begin
        res = '0;
        idx = sh_find(r.chunk);
        if (idx >= 0) begin
          res.hit   = 1'b1;
          res.block = r.chunk;
          res.ctrl  = sh_ctrl[idx];
          res.size  = sh_size[idx];
          res.next  = sh_next[idx];
          res.kind  = sh_kind[idx];
          sh_promote(idx);
        end
        lookups_due.insert(lookups_due.size(), res);
      end
      CMD_UPDATE: begin
        if (r.cpc >= r.sstart) begin
          idx = sh_find(r.chunk);
          if (idx < 0) begin
            idx = sh_victim();
            sh_fill(idx, r, CONF_INIT);
            sh_promote(idx);
          end else if (sh_ctrl[idx] != r.cpc && sh_next[idx] != r.tgt) begin
            if (sh_conf[idx] != CONF_ZERO) sh_conf[idx] = sh_conf[idx] - 1'b1;
            if (sh_conf[idx] == CONF_ZERO) begin
              sh_fill(idx, r, CONF_ZERO);
              sh_promote(idx);
            end
          end
        end
      end
      CMD_COMMIT: begin
        idx = sh_find(r.sstart);
        if (idx >= 0 && sh_ctrl[idx] == r.cpc && sh_next[idx] == r.tgt &&
            sh_conf[idx] != CONF_MAX) begin
          sh_conf[idx] = sh_conf[idx] + 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report(input string line);
    $display("%0t  mismatch: %s", $realtime, line);
    errors++;
  endtask

  task automatic send_item(input fetch_req_t r);
    if (gaps_on && $urandom_range(99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start       <= 1'b1;
    cmd         <= r.op;
    fetch_addr  <= r.chunk;
    stream_base <= r.sstart;
    branch_pc   <= r.cpc;
    target      <= r.tgt;
    branch_size <= r.size;
    end_kind    <= r.kind;
    do @(posedge clk); while (busy !== 1'b0);
    sh_apply(r);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (lookups_due.size() != 0);
  endtask

  task automatic test_empty_lookups();
    send_item(req_of(CMD_PREDICT, ADDR_ALT_A, '0, '0, '0, 4'h0, 3'h0));
    send_item(req_of(CMD_RESERVED, ADDR_ALT_A, '0, ADDR_ALT_A, ADDR_ALT_A, 4'hF, 3'h7));
    send_item(req_of(CMD_COMMIT, ADDR_ALT_A, ADDR_ALT_A, ADDR_ALT_A, ADDR_ALT_A, 4'h0, 3'h0));
  endtask

  task automatic test_install_extremes();
    send_item(req_of(CMD_UPDATE, '0, '0, '0, '0, 4'h0, 3'h0));
    send_item(req_of(CMD_PREDICT, '0, '1, '1, '1, 4'hF, 3'h7));
    send_item(req_of(CMD_UPDATE, '1, '0, '1, '1, 4'hF, 3'h7));
    send_item(req_of(CMD_PREDICT, '1, '0, '0, '0, 4'h0, 3'h0));
  endtask

  task automatic test_update_guard();
    send_item(req_of(CMD_UPDATE, ADDR_ALT_A, ADDR_ALT_A, ADDR_ALT_A - 1'b1, '1, 4'h6, 3'h3));
    send_item(req_of(CMD_PREDICT, ADDR_ALT_A, '0, '0, '0, 4'h0, 3'h0));
    send_item(req_of(CMD_UPDATE, ADDR_ALT_5, ADDR_ALT_5, ADDR_ALT_5, ADDR_ALT_A, 4'h9, 3'h5));
    send_item(req_of(CMD_PREDICT, ADDR_ALT_5, '0, '0, '0, 4'h0, 3'h0));
  endtask

  // entry at all-ones address starts with confidence one
  task automatic test_hysteresis();
    send_item(req_of(CMD_COMMIT, '0, '1, '1, '1, 4'h0, 3'h0));
    send_item(req_of(CMD_COMMIT, '0, '1, '1, '1, 4'h0, 3'h0));
    send_item(req_of(CMD_COMMIT, '0, '1, '1, ADDR_ALT_A, 4'h0, 3'h0));
    send_item(req_of(CMD_COMMIT, '1, '0, '1, '1, 4'h0, 3'h0));
    send_item(req_of(CMD_UPDATE, '1, '0, ADDR_ALT_5, ADDR_ALT_A, 4'h1, 3'h1));
    send_item(req_of(CMD_PREDICT, '1, '0, '0, '0, 4'h0, 3'h0));
    send_item(req_of(CMD_UPDATE, '1, '0, ADDR_ALT_5, ADDR_ALT_5, 4'h3, 3'h2));
    send_item(req_of(CMD_PREDICT, '1, '0, '0, '0, 4'h0, 3'h0));
    send_item(req_of(CMD_UPDATE, '1, '0, ADDR_ALT_5, '0, 4'h7, 3'h6));
    send_item(req_of(CMD_UPDATE, '1, '0, ADDR_ALT_A, ADDR_ALT_A, 4'hC, 3'h4));
    send_item(req_of(CMD_PREDICT, '1, '0, '0, '0, 4'h0, 3'h0));
  endtask

  task automatic new_pool_stream(input int k);
    pool_tag[k]  = rand_addr();
    if ($urandom_range(3) == 0) pool_tag[k] = pool_tag[k] & addr_t'(16'hFFFF);
    pool_cpc[k]  = pool_tag[k] + addr_t'($urandom_range(0, 63));
    pool_tgt[k]  = rand_addr();
    pool_size[k] = SIZE_W'($urandom());
    pool_kind[k] = KIND_W'($urandom());
  endtask

  task automatic test_random_traffic();
    fetch_req_t r;
    int         k;
    int         roll;
    int         sub;
    for (int k0 = 0; k0 < POOL; k0++) new_pool_stream(k0);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = !(n >= 500 && n < 800);
      if (n == 1000) hold_until_drained();
      k    = $urandom_range(POOL - 1);
      roll = $urandom_range(99);
      r    = req_of(CMD_PREDICT, pool_tag[k], rand_addr(), rand_addr(), rand_addr(),
                    SIZE_W'($urandom()), KIND_W'($urandom()));
      if (roll < 10) begin
        r.op    = CMD_W'($urandom());
        r.chunk = $urandom_range(1) ? rand_addr() : pool_tag[k];
      end else if (roll < 48) begin
        r.op = CMD_PREDICT;
      end else if (roll < 78) begin
        sub = $urandom_range(99);
        if (sub < 15) begin
          pool_cpc[k]  = pool_tag[k] + addr_t'($urandom_range(0, 63));
          pool_tgt[k]  = rand_addr();
          pool_size[k] = SIZE_W'($urandom());
          pool_kind[k] = KIND_W'($urandom());
        end
        r.op   = CMD_UPDATE;
        r.cpc  = pool_cpc[k];
        r.tgt  = (sub >= 15 && sub < 22) ? rand_addr() : pool_tgt[k];
        r.size = pool_size[k];
        r.kind = pool_kind[k];
        r.sstart = r.cpc - addr_t'($urandom_range(0, 63));
        if (r.sstart > r.cpc) r.sstart = '0;
      end else if (roll < 98) begin
        r.op     = CMD_COMMIT;
        r.sstart = pool_tag[k];
        r.cpc    = pool_cpc[k];
        r.tgt    = pool_tgt[k];
        sub      = $urandom_range(99);
        if (sub < 8)       r.cpc[$urandom_range(AW - 1)] ^= 1'b1;
        else if (sub < 15) r.tgt[$urandom_range(AW - 1)] ^= 1'b1;
      end else begin
        new_pool_stream(k);
        r.chunk = pool_tag[k];
      end
      send_item(r);
    end
  endtask

  always @(posedge clk) begin : result_check
    lookup_t want;
    if (!rst && res_valid === 1'b1) begin
      if (lookups_due.size() == 0) begin
        report("result with no predict outstanding");
      end else begin
        want = lookups_due.pop_front();
        if (hit !== want.hit)
          report($sformatf("hit got %0h want %0h", hit, want.hit));
        if (block_start !== want.block)
          report($sformatf("block_start got %0h want %0h", block_start, want.block));
        if (pred_control_addr !== want.ctrl)
          report($sformatf("pred_control_addr got %0h want %0h", pred_control_addr,
                           want.ctrl));
        if (pred_branch_size !== want.size)
          report($sformatf("pred_branch_size got %0h want %0h", pred_branch_size,
                           want.size));
        if (pred_next_stream !== want.next)
          report($sformatf("pred_next_stream got %0h want %0h", pred_next_stream,
                           want.next));
        if (pred_end_kind !== want.kind)
          report($sformatf("pred_end_kind got %0h want %0h", pred_end_kind, want.kind));
      end
    end
  end

  // no transfer in either direction for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || res_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("micro_btb_lru_hysteresis_test: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    errors       = 0;
    gaps_on      = 1'b1;
    stall_cycles = 0;
    for (int i = 0; i < NENT; i++) begin
      sh_valid[i] = 1'b0;
      sh_rank[i]  = i;
    end
    rst         <= 1'b1;
    start       <= 1'b0;
    cmd         <= CMD_PREDICT;
    fetch_addr  <= '0;
    stream_base <= '0;
    branch_pc   <= '0;
    target      <= '0;
    branch_size <= '0;
    end_kind    <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_empty_lookups();
    test_install_extremes();
    test_update_guard();
    test_hysteresis();
    test_random_traffic();

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("micro_btb_lru_hysteresis_test: clean");
    end else begin
      $display("micro_btb_lru_hysteresis_test: errors");
    end
    $finish;
  end

endmodule
